// ===== design/gldf_pkg.sv =====
// ---------------------------------------------------------------------------
// gldf_pkg - shared types and constants for the grayscale LED driver feeder
// Beat structs, request/item codes and sequencer states.
// ---------------------------------------------------------------------------
package gldf_pkg;

   localparam int DRIVERS_DEF      = 1;
   localparam int ROWS_DEF         = 6;
   localparam int CH_PER_DRIVER    = 16;
   localparam int BYTES_PER_DRIVER = 24;
   localparam int GRAY_W           = 12;
   localparam int ROW_W            = 3;
   localparam int CHAN_W           = 5;

   // request codes
   localparam logic [1:0] REQ_SET_ONE = 2'd0;
   localparam logic [1:0] REQ_SET_ALL = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;

   // result item kinds
   localparam logic [1:0] KIND_CTRL = 2'd0;
   localparam logic [1:0] KIND_ROW  = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [CHAN_W-1:0] channel;
      logic [GRAY_W-1:0] value;
   } req_beat_type;

   typedef struct packed {
      logic [1:0] item_kind;
      logic [7:0] data_byte;
      logic       leave_program;
      logic       program_exit_clock;
      logic       latch_pulse;
      logic       last;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CTRL,
      ST_ROW,
      ST_DATA
   } state_type;

   // position inside a three-byte channel pair
   typedef enum logic [1:0] {
      PH_HI,
      PH_MID,
      PH_LO
   } phase_type;

endpackage

// ===== design/grayscale_led_driver_feeder.sv =====
// ---------------------------------------------------------------------------
// grayscale_led_driver_feeder - grayscale store and refresh byte sequencer
// Holds one 12-bit level per channel in a small RAM and streams it out
// per refresh tick as a control beat, a row-select beat and packed bytes.
// ---------------------------------------------------------------------------
// Usage:
//  - Request channel: a beat (req_data) is taken on a clock edge with start
//    high and busy low. Set-one and set-all beats give no result; busy stays
//    low, so a new beat may follow every cycle.
//  - A refresh tick raises busy until the final byte beat is registered. The
//    output port gives one result beat per cycle, with the level RAM read
//    two channels per three byte beats.
//  - Result channel: rsp_strobe marks each beat for one cycle. The first
//    beat (control) is registered out after the tick moves the sequencer to
//    its control state, then the row byte, then the grayscale bytes, highest
//    channel first, MSB first; the final byte carries last. Beats leave back to back.
//  - The receiver cannot stall; every strobed beat is final.
//  - Reset (synchronous, active high) empties the store to zero levels,
//    sets row 0, no latch pending and programming mode on. Set-all and reset
//    drop per-channel valid bits so a channel reads the shared fill level.
// ---------------------------------------------------------------------------
module grayscale_led_driver_feeder #(
   parameter int DRIVERS = gldf_pkg::DRIVERS_DEF,
   parameter int ROWS    = gldf_pkg::ROWS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gldf_pkg::req_beat_type req_data,
   output logic                   rsp_strobe,
   output gldf_pkg::rsp_beat_type rsp_data
);
   import gldf_pkg::*;

   localparam int CH = CH_PER_DRIVER * DRIVERS;      // channel count
   localparam int CW = $clog2(CH);                   // RAM address width
   localparam int DB = BYTES_PER_DRIVER * DRIVERS;   // data beats per tick
   localparam int BW = $clog2(DB);                   // byte counter width

   // level store: written on set-one, read through a registered port on a tick
   logic [GRAY_W-1:0] mem [CH];
   logic [GRAY_W-1:0] rd_ff;
   logic              rd_vld_ff;

   // valid bits per channel; invalid channels read the fill level
   logic [CH-1:0]     valid_ff, valid_in;
   logic [GRAY_W-1:0] fill_ff, fill_in;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [CW-1:0]     addr_ff, addr_in;
   logic [BW-1:0]     byte_cnt_ff, byte_cnt_in;
   logic [GRAY_W-1:0] hi_ff, hi_in;
   logic [GRAY_W-1:0] lo_ff, lo_in;
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic              latch_pending_ff, latch_pending_in;
   logic              program_mode_ff, program_mode_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_beat_type      rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [GRAY_W-1:0] rd_val;
   logic              in_range;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // RAM word, or the fill level if the channel was never written since
   // the last set-all / reset
   assign rd_val   = rd_vld_ff ? rd_ff : fill_ff;
   assign in_range = ({1'b0, req_data.channel} < (CHAN_W + 1)'(CH));

   // level RAM, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[req_data.channel[CW-1:0]] <= req_data.value;
      end
      rd_ff     <= mem[addr_ff];
      rd_vld_ff <= valid_ff[addr_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         valid_ff         <= '0;
         fill_ff          <= '0;
         scan_row_ff      <= '0;
         latch_pending_ff <= 1'b0;
         program_mode_ff  <= 1'b1;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         valid_ff         <= valid_in;
         fill_ff          <= fill_in;
         scan_row_ff      <= scan_row_in;
         latch_pending_ff <= latch_pending_in;
         program_mode_ff  <= program_mode_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
   end

   // sequencer datapath, no reset needed
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      addr_ff     <= addr_in;
      byte_cnt_ff <= byte_cnt_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Read schedule: the high channel of a pair is latched into hi_ff before
   // its first byte, and the low channel into lo_ff with that first byte. Pair reads for
   // the next group are issued in the middle and low byte cycles.
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      addr_in          = addr_ff;
      byte_cnt_in      = byte_cnt_ff;
      hi_in            = hi_ff;
      lo_in            = lo_ff;
      valid_in         = valid_ff;
      fill_in          = fill_ff;
      scan_row_in      = scan_row_ff;
      latch_pending_in = latch_pending_ff;
      program_mode_in  = program_mode_ff;
      rsp_strobe_in    = 1'b0;
      rsp_data_in      = rsp_data_ff;
      wr_en            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.req_type)
                  REQ_SET_ONE: begin
                     if (in_range) begin
                        wr_en                              = 1'b1;
                        valid_in[req_data.channel[CW-1:0]] = 1'b1;
                     end
                  end
                  REQ_SET_ALL: begin
                     valid_in = '0;
                     fill_in  = req_data.value;
                  end
                  REQ_TICK: begin
                     addr_in  = CW'(CH - 1);
                     state_in = ST_CTRL;
                  end
                  default: begin
                     // unknown request: dropped
                  end
               endcase
            end
         end

         ST_CTRL: begin
            rsp_strobe_in                  = 1'b1;
            rsp_data_in                    = '0;
            rsp_data_in.item_kind          = KIND_CTRL;
            rsp_data_in.program_exit_clock = program_mode_ff;
            rsp_data_in.latch_pulse        = latch_pending_ff;
            program_mode_in                = 1'b0;
            latch_pending_in               = 1'b0;
            addr_in                        = addr_ff - 1'b1;
            state_in                       = ST_ROW;
         end

         ST_ROW: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in           = '0;
            rsp_data_in.item_kind = KIND_ROW;
            rsp_data_in.data_byte = 8'd1 << scan_row_ff;
            if (({1'b0, scan_row_ff} + 1'b1) < (ROW_W + 1)'(ROWS)) begin
               scan_row_in = scan_row_ff + 1'b1;
            end else begin
               scan_row_in = '0;
            end
            hi_in       = rd_val;
            addr_in     = addr_ff - 1'b1;
            byte_cnt_in = '0;
            phase_in    = PH_HI;
            state_in    = ST_DATA;
         end

         ST_DATA: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in           = '0;
            rsp_data_in.item_kind = KIND_DATA;
            case (phase_ff)
               PH_HI: begin
                  lo_in                 = rd_val;
                  rsp_data_in.data_byte = hi_ff[GRAY_W-1:4];
                  phase_in              = PH_MID;
               end
               PH_MID: begin
                  rsp_data_in.data_byte = {hi_ff[3:0], lo_ff[GRAY_W-1:8]};
                  addr_in               = addr_ff - 1'b1;
                  phase_in              = PH_LO;
               end
               PH_LO: begin
                  rsp_data_in.data_byte = lo_ff[7:0];
                  hi_in                 = rd_val;
                  addr_in               = addr_ff - 1'b1;
                  phase_in              = PH_HI;
               end
               default: begin
                  phase_in = PH_HI;
               end
            endcase
            byte_cnt_in = byte_cnt_ff + 1'b1;
            if (byte_cnt_ff == BW'(DB - 1)) begin
               rsp_data_in.last = 1'b1;
               latch_pending_in = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_last_on_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> (rsp_data.item_kind == KIND_DATA))
      else $error("last flagged on a non-data beat");

   a_ctrl_then_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.item_kind == KIND_CTRL)
      |=> (rsp_strobe && rsp_data.item_kind == KIND_ROW))
      else $error("control beat not followed by row beat");

   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.item_kind == KIND_ROW) |-> $onehot(rsp_data.data_byte))
      else $error("row select byte not one-hot");

   a_data_run_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.item_kind == KIND_DATA && !rsp_data.last)
      |=> (rsp_strobe && rsp_data.item_kind == KIND_DATA))
      else $error("gap inside data byte run");

   a_flags_ctrl_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.item_kind != KIND_CTRL)
      |-> (!rsp_data.program_exit_clock && !rsp_data.latch_pulse))
      else $error("control flags set outside control beat");

endmodule
